>>> hw/rtl/nrto_pkg.sv
// shared constants, codes and types of the nibble reference-count table
package nrto_pkg;

  localparam int FUNCTION_SLOTS = 2048;
  localparam int MODULE_SLOTS   = 2048;
  localparam int OVERFLOW_SLOTS = 16;

  localparam int IDX_W     = 11;
  localparam int BASE_W    = 4;
  localparam int ADD_W     = 20;
  localparam int TOTAL_W   = 21;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam int BASE_AW    = IDX_W + 1;
  localparam int BASE_DEPTH = 1 << BASE_AW;
  localparam int OVF_AW     = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;
  localparam int OVF_CW     = $clog2(OVERFLOW_SLOTS + 1);

  localparam logic [BASE_W-1:0] BASE_FULL    = 4'hf;
  localparam logic [ADD_W-1:0]  ADD_MAX      = 20'hfffff;
  localparam logic [CFG_W-1:0]  IN_USE_RESET = 12'd2048;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DROP = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_UNDERFLOW  = 3'd1,
    STATUS_SATURATED  = 3'd2,
    STATUS_TABLE_FULL = 3'd3,
    STATUS_RANGE      = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FUNCTIONS_IN_USE = 2'd0,
    CFG_MODULES_IN_USE   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

>>> hw/rtl/nrto_ram.sv
// generic single-write, single-read ram with registered read data
module nrto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/nibble_refcount_table_with_overflow_unit.sv
// top level of the nibble reference-count table with overflow records
//
// Counts references for two namespaces (functions and modules). A request word
// on the input channel (req_type, is_function, entry_index) adds, drops or reads
// one entry; every request yields exactly one result word (total_count, status).
// Both channels move a word at an edge where valid is high and stall is low.
// Base counters sit in one 4096 x 4 ram; overflow additions sit in a small ram
// whose keys are searched in flip-flops while the request word is taken.
// The result is registered in the output register when the execute step ends.
// A new request is taken only once the last one has left the execute state:
// the base counter ram is read at accept and written back as execute ends.
// Receiver stall: a finished result holds in the output register; a request
// already taken waits in the execute state until the register is free, and no
// new request is taken meanwhile.
// Reset: synchronous, active high. After reset a clearing pass zeroes all 4096
// entries of the base counter ram, one entry a cycle; in_stall is high during
// it. Configuration writes (cfg_valid/cfg_ready) are taken at any time.
module nibble_refcount_table_with_overflow_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic                              is_function,
  input  logic [nrto_pkg::IDX_W-1:0]        entry_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nrto_pkg::TOTAL_W-1:0]      total_count,
  output logic [nrto_pkg::STATUS_W-1:0]     status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nrto_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nrto_pkg::CFG_W-1:0]        cfg_data
);
  import nrto_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]   functions_in_use;
  logic [CFG_W-1:0]   modules_in_use;
  logic [BASE_AW-1:0] clr_addr;
  logic [OVF_CW-1:0]  ovf_used;
  logic               ovf_fn  [OVERFLOW_SLOTS];
  logic [IDX_W-1:0]   ovf_idx [OVERFLOW_SLOTS];

  logic [1:0]         req_q;
  logic               fn_q;
  logic [IDX_W-1:0]   idx_q;
  logic               range_q;
  logic               hit_q;
  logic [OVF_AW-1:0]  hit_sel_q;

  logic               accept;
  logic               exec_done;
  logic               hit;
  logic [OVF_AW-1:0]  hit_sel;
  logic [CFG_W-1:0]   limit;
  logic [CFG_W-1:0]   slots_lim;
  logic               range_bad;
  logic               used_full;

  logic               base_we;
  logic [BASE_W-1:0]  base_wd;
  logic               add_we;
  logic [OVF_AW-1:0]  add_waddr;
  logic [ADD_W-1:0]   add_wd;
  logic               alloc;
  logic [TOTAL_W-1:0] cnt;
  status_t            st;

  logic               base_ram_we;
  logic [BASE_AW-1:0] base_ram_waddr;
  logic [BASE_W-1:0]  base_ram_wdata;
  logic [BASE_W-1:0]  base_rd;
  logic [ADD_W-1:0]   add_rd;
  logic [TOTAL_W-1:0] total_full;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign exec_done = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign used_full = (ovf_used == OVF_CW'(OVERFLOW_SLOTS));

  // overflow key search, lowest slot wins
  always_comb begin
    hit     = 1'b0;
    hit_sel = '0;
    for (int i = OVERFLOW_SLOTS - 1; i >= 0; i--) begin
      if ((OVF_CW'(i) < ovf_used) && (ovf_fn[i] == is_function) &&
          (ovf_idx[i] == entry_index)) begin
        hit     = 1'b1;
        hit_sel = OVF_AW'(i);
      end
    end
  end

  always_comb begin
    limit     = is_function ? functions_in_use : modules_in_use;
    slots_lim = is_function ? CFG_W'(FUNCTION_SLOTS) : CFG_W'(MODULE_SLOTS);
    range_bad = ({1'b0, entry_index} >= limit) || ({1'b0, entry_index} >= slots_lim);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == BASE_AW'(BASE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    case (state)
      ST_IDLE: in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  // modify step
  always_comb begin
    base_we    = 1'b0;
    base_wd    = base_rd;
    add_we     = 1'b0;
    add_waddr  = hit_sel_q;
    add_wd     = add_rd;
    alloc      = 1'b0;
    cnt        = '0;
    st         = STATUS_OK;
    total_full = TOTAL_W'(BASE_FULL) + TOTAL_W'(add_rd);
    if (range_q) begin
      st = STATUS_RANGE;
    end else begin
      case (req_q)
        REQ_ADD: begin
          if (base_rd != BASE_FULL) begin
            base_we = 1'b1;
            base_wd = base_rd + BASE_W'(1);
            cnt     = TOTAL_W'(base_wd);
          end else if (hit_q) begin
            if (add_rd == ADD_MAX) begin
              st  = STATUS_SATURATED;
              cnt = total_full;
            end else begin
              add_we = 1'b1;
              add_wd = add_rd + ADD_W'(1);
              cnt    = total_full + TOTAL_W'(1);
            end
          end else if (!used_full) begin
            alloc     = 1'b1;
            add_we    = 1'b1;
            add_waddr = ovf_used[OVF_AW-1:0];
            add_wd    = ADD_W'(1);
            cnt       = TOTAL_W'(BASE_FULL) + TOTAL_W'(1);
          end else begin
            st  = STATUS_TABLE_FULL;
            cnt = TOTAL_W'(BASE_FULL);
          end
        end
        REQ_DROP: begin
          if (base_rd != BASE_FULL) begin
            if (base_rd == '0) begin
              st = STATUS_UNDERFLOW;
            end else begin
              base_we = 1'b1;
              base_wd = base_rd - BASE_W'(1);
              cnt     = TOTAL_W'(base_wd);
            end
          end else if (!hit_q || (add_rd == '0)) begin
            base_we = 1'b1;
            base_wd = BASE_FULL - BASE_W'(1);
            cnt     = TOTAL_W'(base_wd);
          end else begin
            add_we = 1'b1;
            add_wd = add_rd - ADD_W'(1);
            cnt    = total_full - TOTAL_W'(1);
          end
        end
        default: begin
          if (base_rd != BASE_FULL) begin
            cnt = TOTAL_W'(base_rd);
          end else if (hit_q) begin
            cnt = total_full;
          end else begin
            cnt = TOTAL_W'(BASE_FULL);
          end
        end
      endcase
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      base_ram_we    = 1'b1;
      base_ram_waddr = clr_addr;
      base_ram_wdata = '0;
    end else begin
      base_ram_we    = base_we && exec_done;
      base_ram_waddr = {fn_q, idx_q};
      base_ram_wdata = base_wd;
    end
  end

  nrto_ram #(
    .WIDTH(BASE_W),
    .DEPTH(BASE_DEPTH)
  ) u_base_ram (
    .clk    (clk),
    .wr_en  (base_ram_we),
    .wr_addr(base_ram_waddr),
    .wr_data(base_ram_wdata),
    .rd_en  (accept),
    .rd_addr({is_function, entry_index}),
    .rd_data(base_rd)
  );

  nrto_ram #(
    .WIDTH(ADD_W),
    .DEPTH(OVERFLOW_SLOTS)
  ) u_add_ram (
    .clk    (clk),
    .wr_en  (add_we && exec_done),
    .wr_addr(add_waddr),
    .wr_data(add_wd),
    .rd_en  (accept),
    .rd_addr(hit_sel),
    .rd_data(add_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      ovf_used         <= '0;
      out_valid        <= 1'b0;
      functions_in_use <= IN_USE_RESET;
      modules_in_use   <= IN_USE_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BASE_AW'(1);
      end
      if (exec_done && alloc) begin
        ovf_used <= ovf_used + OVF_CW'(1);
      end
      if (exec_done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FUNCTIONS_IN_USE) begin
          functions_in_use <= cfg_data;
        end else if (cfg_index == CFG_MODULES_IN_USE) begin
          modules_in_use <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q     <= req_type;
      fn_q      <= is_function;
      idx_q     <= entry_index;
      range_q   <= range_bad;
      hit_q     <= hit;
      hit_sel_q <= hit_sel;
    end
    if (exec_done) begin
      total_count <= cnt;
      status      <= st;
    end
    if (exec_done && alloc) begin
      ovf_fn[ovf_used[OVF_AW-1:0]]  <= fn_q;
      ovf_idx[ovf_used[OVF_AW-1:0]] <= idx_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    ovf_used <= OVF_CW'(OVERFLOW_SLOTS))
    else $error("overflow record count beyond table size");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted request did not enter execute");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("request taken during clearing pass");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EXEC))
    else $error("result shown without a request in execute");

  a_range_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_RANGE)) |-> (total_count == '0))
    else $error("out of range result with nonzero count");
`endif

endmodule

>>> tb/refcount_checker.sv
// checker for the refcount table: follows every word on both channels, predicts and compares
`timescale 1ns / 1ps
module refcount_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic                           is_function,
  input  logic [nrto_pkg::IDX_W-1:0]     entry_index,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [nrto_pkg::TOTAL_W-1:0]   total_count,
  input  logic [nrto_pkg::STATUS_W-1:0]  status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [nrto_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nrto_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  import nrto_pkg::*;

  localparam int NS_SLOTS = (FUNCTION_SLOTS > MODULE_SLOTS) ? FUNCTION_SLOTS : MODULE_SLOTS;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    status_t            stat;
  } count_word_t;

  typedef struct {
    logic             fn;
    logic [IDX_W-1:0] idx;
    logic [ADD_W-1:0] extra;
  } overflow_rec_t;

  logic [BASE_W-1:0] base_count [2][NS_SLOTS];
  overflow_rec_t     overflow_rec [OVERFLOW_SLOTS];
  int                overflow_used = 0;
  logic [CFG_W-1:0]  functions_limit = IN_USE_RESET;
  logic [CFG_W-1:0]  modules_limit = IN_USE_RESET;
  count_word_t       expected_counts [$];
  count_word_t       want;
  int                errors = 0;

  function automatic int find_record(input logic fn, input logic [IDX_W-1:0] idx);
    for (int i = 0; i < overflow_used; i++) begin
      if (overflow_rec[i].fn == fn && overflow_rec[i].idx == idx) return i;
    end
    return -1;
  endfunction

  function automatic count_word_t predict_count(input logic [1:0] rq, input logic fn,
                                                input logic [IDX_W-1:0] idx);
    count_word_t w;
    int lim;
    int slots;
    int r;
    logic [BASE_W-1:0] b;
    w.total = '0;
    w.stat = STATUS_OK;
    lim = fn ? int'(functions_limit) : int'(modules_limit);
    slots = fn ? FUNCTION_SLOTS : MODULE_SLOTS;
    if (int'(idx) >= lim || int'(idx) >= slots) begin
      w.stat = STATUS_RANGE;
      return w;
    end
    b = base_count[fn][idx];
    r = (b == BASE_FULL) ? find_record(fn, idx) : -1;
    if (rq == REQ_ADD) begin
      if (b != BASE_FULL) begin
        base_count[fn][idx] = b + 1'b1;
        w.total = TOTAL_W'(b) + 1'b1;
      end else if (r >= 0) begin
        if (overflow_rec[r].extra == ADD_MAX) w.stat = STATUS_SATURATED;
        else overflow_rec[r].extra = overflow_rec[r].extra + 1'b1;
        w.total = TOTAL_W'(BASE_FULL) + TOTAL_W'(overflow_rec[r].extra);
      end else if (overflow_used < OVERFLOW_SLOTS) begin
        overflow_rec[overflow_used].fn = fn;
        overflow_rec[overflow_used].idx = idx;
        overflow_rec[overflow_used].extra = ADD_W'(1);
        overflow_used++;
        w.total = TOTAL_W'(BASE_FULL) + 1'b1;
      end else begin
        w.stat = STATUS_TABLE_FULL;
        w.total = TOTAL_W'(BASE_FULL);
      end
    end else if (rq == REQ_DROP) begin
      if (b == '0) begin
        w.stat = STATUS_UNDERFLOW;
      end else if (b != BASE_FULL) begin
        base_count[fn][idx] = b - 1'b1;
        w.total = TOTAL_W'(b - 1'b1);
      end else if (r < 0 || overflow_rec[r].extra == '0) begin
        // full base with nothing in the overflow record falls back to 14
        base_count[fn][idx] = BASE_FULL - 1'b1;
        w.total = TOTAL_W'(BASE_FULL - 1'b1);
      end else begin
        overflow_rec[r].extra = overflow_rec[r].extra - 1'b1;
        w.total = TOTAL_W'(BASE_FULL) + TOTAL_W'(overflow_rec[r].extra);
      end
    end else begin
      if (b != BASE_FULL) w.total = TOTAL_W'(b);
      else if (r >= 0) w.total = TOTAL_W'(BASE_FULL) + TOTAL_W'(overflow_rec[r].extra);
      else w.total = TOTAL_W'(BASE_FULL);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (base_count[n, i]) base_count[n][i] = '0;
      overflow_used = 0;
      functions_limit = IN_USE_RESET;
      modules_limit = IN_USE_RESET;
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FUNCTIONS_IN_USE: functions_limit = cfg_data;
          CFG_MODULES_IN_USE:   modules_limit = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch("result word with nothing outstanding, total_count", total_count, 0);
        end else begin
          want = expected_counts.pop_front();
          if (total_count !== want.total) report_mismatch("total_count", total_count, want.total);
          if (status !== want.stat) report_mismatch("status", status, want.stat);
        end
      end
      if (in_valid && !in_stall) begin
        expected_counts.push_back(predict_count(req_type, is_function, entry_index));
      end
    end
    pending_count <= expected_counts.size();
    fail_count <= errors;
  end

endmodule

>>> tb/testbench.sv
// top of the refcount table testbench: clock, reset, request and register stimulus, verdict
`timescale 1ns / 1ps
module testbench;
  import nrto_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int FILL_ENTRIES = OVERFLOW_SLOTS + 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CHUNKS = 6;
  localparam int QUIET_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           req_type;
  logic                 is_function;
  logic [IDX_W-1:0]     entry_index;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TOTAL_W-1:0]   total_count;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending_count;
  int                   quiet_cycles = 0;
  int                   stall_left = 0;
  bit                   no_idle = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nibble_refcount_table_with_overflow_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .is_function (is_function),
    .entry_index (entry_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .total_count (total_count),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  refcount_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .is_function   (is_function),
    .entry_index   (entry_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .total_count   (total_count),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return IN_USE_RESET;
    if (r < 65) return '1;
    if (r < 72) return '0;
    if (r < 80) return CFG_W'(1);
    return CFG_W'($urandom_range(1024, 2047));
  endfunction

  function automatic logic fill_fn(input int k);
    return 1'(k);
  endfunction

  function automatic logic [IDX_W-1:0] fill_idx(input int k);
    return IDX_W'(k * 120 + 7);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      stall_left <= pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles where no word moves anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_req(input logic [1:0] rq, input logic fn, input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    is_function <= fn;
    entry_index <= idx;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] fn_lim, input logic [CFG_W-1:0] mod_lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FUNCTIONS_IN_USE;
    cfg_data <= fn_lim;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= CFG_MODULES_IN_USE;
    cfg_data <= mod_lim;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_chunk(input int count, input int add_pct);
    int r;
    int k;
    logic [1:0] rq;
    logic fn;
    logic [IDX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) rq = REQ_UNKNOWN;
      else if (r < 3 + add_pct) rq = REQ_ADD;
      else if ($urandom_range(0, 2) != 0) rq = REQ_DROP;
      else rq = REQ_READ;
      // most words go to a few busy entries so counts climb into the overflow records
      if ($urandom_range(0, 99) < 65) begin
        k = $urandom_range(0, FILL_ENTRIES + 5);
        if (k < FILL_ENTRIES) begin
          fn = fill_fn(k);
          idx = fill_idx(k);
        end else begin
          fn = 1'($urandom_range(0, 1));
          if (k == FILL_ENTRIES) idx = '0;
          else if (k == FILL_ENTRIES + 1) idx = '1;
          else idx = IDX_W'(k);
        end
      end else begin
        fn = 1'($urandom_range(0, 1));
        idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      end
      send_req(rq, fn, idx);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_READ;
    is_function <= 1'b0;
    entry_index <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FUNCTIONS_IN_USE;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_limits(IN_USE_RESET, IN_USE_RESET);

    // directed words
    send_req(REQ_READ, 1'b0, '0);
    send_req(REQ_READ, 1'b1, '1);
    send_req(REQ_DROP, 1'b0, '0);
    send_req(REQ_ADD, 1'b0, '0);
    send_req(REQ_ADD, 1'b1, '1);
    send_req(REQ_DROP, 1'b1, '1);
    send_req(REQ_UNKNOWN, 1'b1, '1);
    send_req(REQ_ADD, 1'b1, 11'h400);
    send_req(REQ_UNKNOWN, 1'b1, 11'h400);
    send_req(REQ_DROP, 1'b0, '0);
    send_req(REQ_ADD, 1'b0, '1);
    send_req(REQ_ADD, 1'b0, 11'h555);
    send_req(REQ_ADD, 1'b1, 11'h2aa);
    wait_drained();
    set_limits('0, '1);
    send_req(REQ_ADD, 1'b1, '0);
    send_req(REQ_READ, 1'b0, '1);
    send_req(REQ_DROP, 1'b1, '1);
    wait_drained();
    set_limits(CFG_W'(1), CFG_W'(1));
    send_req(REQ_ADD, 1'b1, '0);
    send_req(REQ_ADD, 1'b1, 11'd1);
    send_req(REQ_READ, 1'b0, 11'd1);
    send_req(REQ_READ, 1'b0, '0);
    wait_drained();
    set_limits(CFG_W'(2047), IN_USE_RESET);
    send_req(REQ_READ, 1'b1, '1);
    send_req(REQ_ADD, 1'b1, 11'd2046);
    send_req(REQ_DROP, 1'b0, '1);
    wait_drained();
    set_limits(IN_USE_RESET, IN_USE_RESET);

    // use up every overflow record, then one more entry runs into a full table
    for (int k = 0; k < FILL_ENTRIES; k++) begin
      repeat (int'(BASE_FULL) + 2) send_req(REQ_ADD, fill_fn(k), fill_idx(k));
    end
    send_req(REQ_DROP, fill_fn(FILL_ENTRIES - 1), fill_idx(FILL_ENTRIES - 1));
    send_req(REQ_DROP, fill_fn(0), fill_idx(0));
    send_req(REQ_DROP, fill_fn(0), fill_idx(0));
    send_req(REQ_DROP, fill_fn(0), fill_idx(0));
    send_req(REQ_READ, fill_fn(0), fill_idx(0));
    send_req(REQ_ADD, fill_fn(0), fill_idx(0));
    send_req(REQ_ADD, fill_fn(0), fill_idx(0));

    for (int c = 0; c < CHUNKS; c++) begin
      if (c > 0) begin
        wait_drained();
        set_limits(pick_limit(), pick_limit());
      end
      no_idle = (c == 2);
      if (c == 3) begin
        random_chunk(RANDOM_ITEMS / CHUNKS / 2, 35);
        wait_drained();
        random_chunk(RANDOM_ITEMS / CHUNKS - RANDOM_ITEMS / CHUNKS / 2, 35);
      end else begin
        random_chunk(RANDOM_ITEMS / CHUNKS, (c % 2 == 0) ? 65 : 35);
      end
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> nibble_refcount_table_with_overflow_unit.f
hw/rtl/nrto_pkg.sv
hw/rtl/nrto_ram.sv
hw/rtl/nibble_refcount_table_with_overflow_unit.sv
tb/refcount_checker.sv
tb/testbench.sv
